FILE: sv/swt_pkg.sv
// Shared types and constants for the sideband window table.
package swt_pkg;

    localparam int          WORD_W          = 32;
    localparam int          INDEX_W         = 7;
    localparam int          NUM_WINDOWS_DEF = 128;
    localparam int          WORDS_PER_GROUP = 8;
    localparam int          SLOT_W          = 3;
    localparam int          REGION_BITS     = 12;
    localparam int          GROUP_LSB       = 5;
    localparam logic [31:0] REGION_BASE     = 32'hF00A_9000;
    localparam logic [3:0]  ACCESS_BYTES    = 4'd4;

    localparam logic [SLOT_W-1:0] OFF_BASE     = 3'd0;
    localparam logic [SLOT_W-1:0] OFF_SIZE     = 3'd1;
    localparam logic [SLOT_W-1:0] OFF_FLAGS    = 3'd2;
    localparam logic [SLOT_W-1:0] OFF_SIDEBAND = 3'd6;
    localparam int                ENABLE_BIT   = 0;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_LOOKUP
    } op_kind_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic write_go;
        logic read_go;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } swt_cmd_t;

    typedef struct packed {
        op_kind_t kind;
        logic     clear_last;
        logic     scan_done;
    } swt_sts_t;

endpackage

FILE: sv/swt_ram.sv
// Generic single-port RAM with registered read data.
module swt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/swt_ctrl.sv
// Sequencer for clearing, bus accesses, window scans and result hand-off.
module swt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  swt_pkg::swt_sts_t sts,
    output swt_pkg::swt_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.kind)
                    swt_pkg::OP_READ:
                    begin
                        cmd.read_go = 1'b1;
                        state_next  = ST_RD_WAIT;
                    end
                    swt_pkg::OP_WRITE:
                    begin
                        cmd.write_go = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    swt_pkg::OP_LOOKUP:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                // stop on the first match or after the last window
                if (sts.scan_done)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/swt_dp.sv
// Datapath: access decode, window word RAMs, scan compare and result register.
module swt_dp #(
    parameter int NUM_WINDOWS = swt_pkg::NUM_WINDOWS_DEF,
    localparam int WIN_AW     = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swt_pkg::swt_cmd_t            cmd,
    output swt_pkg::swt_sts_t            sts,
    input  logic [1:0]                   mode,
    input  logic [31:0]                  bus_address,
    input  logic [3:0]                   access_size,
    input  logic [31:0]                  write_data,
    input  logic [31:0]                  lookup_address,
    output logic                         claimed,
    output logic                         misaligned,
    output logic [31:0]                  read_data,
    output logic                         hit,
    output logic [swt_pkg::INDEX_W-1:0]  window_index,
    output logic [31:0]                  window_sideband_address
);

    localparam int          GROUP_W  = swt_pkg::REGION_BITS - swt_pkg::GROUP_LSB;
    localparam logic [WIN_AW-1:0] LAST_IDX = WIN_AW'(NUM_WINDOWS - 1);

    // decode of the incoming word
    logic [31:0]         offset;
    logic                in_region;
    logic                bad_access;
    logic [GROUP_W-1:0]  group;
    logic                in_range;
    logic                is_bus;
    swt_pkg::op_kind_t   kind_in;

    // captured item
    swt_pkg::op_kind_t          kind_reg;
    logic                       claimed_reg;
    logic                       misaligned_reg;
    logic                       good_reg;
    logic [WIN_AW-1:0]          row_reg;
    logic [swt_pkg::SLOT_W-1:0] slot_reg;
    logic [31:0]                wdata_reg;
    logic [31:0]                laddr_reg;

    // counters
    logic [WIN_AW-1:0] clr_idx_reg;
    logic [WIN_AW-1:0] clr_idx_next;
    logic [WIN_AW-1:0] scan_idx_reg;
    logic [WIN_AW-1:0] scan_idx_next;

    // RAM side
    logic [WIN_AW-1:0] ram_addr;
    logic              ram_re;
    logic [31:0]       ram_wdata;
    logic [31:0]       rd [swt_pkg::WORDS_PER_GROUP];

    // scan compare
    logic [31:0] win_top;
    logic        match;
    logic        scan_last;
    logic        lookup_hit;

    // result register
    logic                        out_claimed_reg;
    logic                        out_misaligned_reg;
    logic [31:0]                 out_read_data_reg;
    logic                        out_hit_reg;
    logic [swt_pkg::INDEX_W-1:0] out_index_reg;
    logic [31:0]                 out_sideband_reg;

    assign offset     = bus_address - swt_pkg::REGION_BASE;
    assign in_region  = (offset[31:swt_pkg::REGION_BITS] == '0);
    assign bad_access = (access_size != swt_pkg::ACCESS_BYTES) || (offset[1:0] != 2'b00);
    assign group      = offset[swt_pkg::REGION_BITS-1:swt_pkg::GROUP_LSB];
    assign in_range   = ({1'b0, group} < (GROUP_W + 1)'(NUM_WINDOWS));
    assign is_bus     = mode inside {swt_pkg::MODE_READ, swt_pkg::MODE_WRITE};

    always_comb
    begin
        case (mode)
            swt_pkg::MODE_READ:   kind_in = swt_pkg::OP_READ;
            swt_pkg::MODE_WRITE:  kind_in = swt_pkg::OP_WRITE;
            swt_pkg::MODE_LOOKUP: kind_in = swt_pkg::OP_LOOKUP;
            default:              kind_in = swt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            claimed_reg    <= is_bus && in_region;
            misaligned_reg <= is_bus && in_region && bad_access;
            good_reg       <= in_region && !bad_access && in_range;
            row_reg        <= group[WIN_AW-1:0];
            slot_reg       <= offset[swt_pkg::GROUP_LSB-1:2];
            wdata_reg      <= write_data;
            laddr_reg      <= lookup_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= swt_pkg::OP_NONE;
            clr_idx_reg  <= '0;
            scan_idx_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                kind_reg <= kind_in;
            end
            clr_idx_reg  <= clr_idx_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        scan_idx_next = scan_idx_reg;
        if (cmd.clear)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
    end

    // one address for all word RAMs: clear sweep, scan, or the captured row
    always_comb
    begin
        if (cmd.clear)
        begin
            ram_addr = clr_idx_reg;
        end
        else if (cmd.scan_start || cmd.scan_step)
        begin
            ram_addr = scan_idx_next;
        end
        else
        begin
            ram_addr = row_reg;
        end
    end

    assign ram_re    = cmd.read_go || cmd.scan_start || cmd.scan_step;
    assign ram_wdata = cmd.clear ? 32'd0 : wdata_reg;

    for (genvar w = 0; w < swt_pkg::WORDS_PER_GROUP; w++)
    begin : g_slot
        logic slot_we;

        assign slot_we = cmd.clear ||
                         (cmd.write_go && good_reg &&
                          (slot_reg == swt_pkg::SLOT_W'(w)));

        swt_ram #(
            .WIDTH (swt_pkg::WORD_W),
            .DEPTH (NUM_WINDOWS)
        ) u_ram (
            .clk   (clk),
            .we    (slot_we),
            .re    (ram_re),
            .addr  (ram_addr),
            .wdata (ram_wdata),
            .rdata (rd[w])
        );
    end

    assign win_top    = rd[swt_pkg::OFF_BASE] + rd[swt_pkg::OFF_SIZE];
    assign match      = rd[swt_pkg::OFF_FLAGS][swt_pkg::ENABLE_BIT] &&
                        (laddr_reg >= rd[swt_pkg::OFF_BASE]) &&
                        (laddr_reg <= win_top);
    assign scan_last  = (scan_idx_reg == LAST_IDX);
    assign lookup_hit = (kind_reg == swt_pkg::OP_LOOKUP) && match;

    assign sts.kind       = kind_reg;
    assign sts.clear_last = (clr_idx_reg == LAST_IDX);
    assign sts.scan_done  = match || scan_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_claimed_reg    <= claimed_reg && (kind_reg != swt_pkg::OP_LOOKUP);
            out_misaligned_reg <= misaligned_reg && (kind_reg != swt_pkg::OP_LOOKUP);
            out_read_data_reg  <= ((kind_reg == swt_pkg::OP_READ) && good_reg) ?
                                  rd[slot_reg] : 32'd0;
            out_hit_reg        <= lookup_hit;
            out_index_reg      <= lookup_hit ? swt_pkg::INDEX_W'(scan_idx_reg) : '0;
            out_sideband_reg   <= lookup_hit ? rd[swt_pkg::OFF_SIDEBAND] : 32'd0;
        end
    end

    assign claimed                 = out_claimed_reg;
    assign misaligned              = out_misaligned_reg;
    assign read_data               = out_read_data_reg;
    assign hit                     = out_hit_reg;
    assign window_index            = out_index_reg;
    assign window_sideband_address = out_sideband_reg;

endmodule

FILE: sv/sideband_window_table_top.sv
// Top level of the sideband window table: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  in      | into      | in_valid / in_stall | mode, bus_address, access_size,
//          |           |                     | write_data, lookup_address
//  out     | out of    | out_valid/out_stall | claimed, misaligned, read_data, hit,
//          |           |                     | window_index, window_sideband_address
//
// One word at a time. A bus write or unused mode is captured, executed and loaded into
// the output register; a bus read first waits for the RAM read data; a lookup scans k
// windows (1 to NUM_WINDOWS), one window read per cycle from the word RAMs.
// After reset a clearing pass writes zero to all windows, with in_stall held high.
// A finished word waits in the output register; the next input word is taken
// while it is stalled, and a new result waits until the register is free.
module sideband_window_table_top #(
    parameter int NUM_WINDOWS = swt_pkg::NUM_WINDOWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [31:0]                  bus_address,
    input  logic [3:0]                   access_size,
    input  logic [31:0]                  write_data,
    input  logic [31:0]                  lookup_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         claimed,
    output logic                         misaligned,
    output logic [31:0]                  read_data,
    output logic                         hit,
    output logic [swt_pkg::INDEX_W-1:0]  window_index,
    output logic [31:0]                  window_sideband_address
);

    swt_pkg::swt_cmd_t cmd;
    swt_pkg::swt_sts_t sts;

    swt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    swt_dp #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .sts                     (sts),
        .mode                    (mode),
        .bus_address             (bus_address),
        .access_size             (access_size),
        .write_data              (write_data),
        .lookup_address          (lookup_address),
        .claimed                 (claimed),
        .misaligned              (misaligned),
        .read_data               (read_data),
        .hit                     (hit),
        .window_index            (window_index),
        .window_sideband_address (window_sideband_address)
    );

endmodule

FILE: sv/swt_checker.sv
// Port-level checks for the sideband window table, bound to the top level.
module swt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         claimed,
    input logic                         misaligned,
    input logic [31:0]                  read_data,
    input logic                         hit,
    input logic [swt_pkg::INDEX_W-1:0]  window_index,
    input logic [31:0]                  window_sideband_address
);

    // a lookup hit carries no bus status
    a_hit_excludes_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !claimed && !misaligned && (read_data == 32'd0))
        else $error("lookup hit with bus status set");

    // a rejected access is claimed and returns no data
    a_misaligned_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && misaligned |-> claimed && (read_data == 32'd0))
        else $error("misaligned access not claimed or returned data");

    // a miss reports zero index and sideband address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (window_index == '0) && (window_sideband_address == 32'd0))
        else $error("miss with nonzero window fields");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(hit) &&
                                   $stable(window_index) && $stable(claimed))
        else $error("stalled result word changed");

endmodule

bind sideband_window_table_top swt_checker u_swt_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .claimed                 (claimed),
    .misaligned              (misaligned),
    .read_data               (read_data),
    .hit                     (hit),
    .window_index            (window_index),
    .window_sideband_address (window_sideband_address)
);
